/* hw/rtl/crccfv_pkg.sv */
// crccfv_pkg: shared types, constants and the byte-wide crc update for the
// crc checked frame validator. No dependencies.
package crccfv_pkg;

    localparam int unsigned HEADER_BYTES = 10;
    localparam int unsigned POS_W        = 17;
    localparam int unsigned OUT_TDATA_W  = 40;

    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
    localparam logic [15:0]      CRC_INIT = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY = 16'h1021;

    // configuration register indexes
    localparam logic CFG_SIGNATURE = 1'b0;
    localparam logic CFG_VERSION   = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_BAD_SIG   = 3'd2,
        STATUS_BAD_VER   = 3'd3,
        STATUS_TRUNCATED = 3'd4,
        STATUS_CRC_ERR   = 3'd5
    } t_status;

    // crc-16/ccitt-false, msb first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crc_checked_frame_validator_unit.sv */
// crc_checked_frame_validator_unit: byte stream frame header check and
// crc-16/ccitt-false payload check. Depends on crccfv_pkg.
//
// Takes one frame byte per clock on the s_axis side and returns one status
// request on m_axis for every byte marked tlast. Sustained rate is one byte
// per cycle unless stalled: each byte passes through an input register,
// then header compare and byte-wide crc update into the frame state and
// the result register, which holds a frame's status until it is taken.
// The result register lets the next frame stream in while a status
// waits; input stalls only when a second last byte meets an untaken result.
// Header is 10 bytes big endian: signature, version, payload length, crc.
module crc_checked_frame_validator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [crccfv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
    // m_axis_tdata: [2:0] status, [18:3] payload_length, [34:19] crc_value,
    // [39:35] zero
);

    logic [31:0] r_exp_sig;
    logic [15:0] r_exp_ver;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic [crccfv_pkg::POS_W-1:0] r_pos, n_pos;
    logic        r_sig_ok, n_sig_ok;
    logic        r_ver_ok, n_ver_ok;
    logic [15:0] r_hdr_len, n_hdr_len;
    logic [15:0] r_hdr_crc, n_hdr_crc;
    logic [15:0] r_crc, n_crc;

    logic                r_out_valid;
    crccfv_pkg::t_status r_out_status, n_status;
    logic [15:0]         r_out_len;
    logic [15:0]         r_out_crc;

    logic       w_adv;
    logic [7:0] w_want;
    logic [crccfv_pkg::POS_W-1:0] w_count;
    logic [crccfv_pkg::POS_W-1:0] w_need;

    assign w_adv = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_crc, r_out_len, r_out_status};

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_sig <= 32'd0;
            r_exp_ver <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                crccfv_pkg::CFG_SIGNATURE: r_exp_sig <= i_cfg_data;
                crccfv_pkg::CFG_VERSION:   r_exp_ver <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // expected header byte for the current position
    always_comb begin
        case (r_pos[2:0])
            3'd0:    w_want = r_exp_sig[31:24];
            3'd1:    w_want = r_exp_sig[23:16];
            3'd2:    w_want = r_exp_sig[15:8];
            3'd3:    w_want = r_exp_sig[7:0];
            3'd4:    w_want = r_exp_ver[15:8];
            3'd5:    w_want = r_exp_ver[7:0];
            default: w_want = 8'h00;
        endcase
    end

    // per-byte state update
    always_comb begin
        n_sig_ok  = r_sig_ok;
        n_ver_ok  = r_ver_ok;
        n_hdr_len = r_hdr_len;
        n_hdr_crc = r_hdr_crc;
        n_crc     = r_crc;
        if (r_pos < crccfv_pkg::POS_W'(4)) begin
            if (r_in_byte != w_want) n_sig_ok = 1'b0;
        end else if (r_pos < crccfv_pkg::POS_W'(6)) begin
            if (r_in_byte != w_want) n_ver_ok = 1'b0;
        end else if (r_pos < crccfv_pkg::POS_W'(8)) begin
            n_hdr_len = {r_hdr_len[7:0], r_in_byte};
        end else if (r_pos < crccfv_pkg::POS_W'(crccfv_pkg::HEADER_BYTES)) begin
            n_hdr_crc = {r_hdr_crc[7:0], r_in_byte};
        end else if ((r_pos - crccfv_pkg::POS_W'(crccfv_pkg::HEADER_BYTES))
                     < {1'b0, r_hdr_len}) begin
            n_crc = crccfv_pkg::crc_byte(r_crc, r_in_byte);
        end
        n_pos = (r_pos == crccfv_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
    end

    assign w_count = n_pos;
    assign w_need  = crccfv_pkg::POS_W'(crccfv_pkg::HEADER_BYTES) + {1'b0, n_hdr_len};

    always_comb begin
        if (w_count < crccfv_pkg::POS_W'(crccfv_pkg::HEADER_BYTES)) begin
            n_status = crccfv_pkg::STATUS_SHORT;
        end else if (!n_sig_ok) begin
            n_status = crccfv_pkg::STATUS_BAD_SIG;
        end else if (!n_ver_ok) begin
            n_status = crccfv_pkg::STATUS_BAD_VER;
        end else if (w_need > w_count) begin
            n_status = crccfv_pkg::STATUS_TRUNCATED;
        end else if (n_crc != n_hdr_crc) begin
            n_status = crccfv_pkg::STATUS_CRC_ERR;
        end else begin
            n_status = crccfv_pkg::STATUS_OK;
        end
    end

    // frame state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_sig_ok  <= 1'b1;
            r_ver_ok  <= 1'b1;
            r_hdr_len <= 16'd0;
            r_hdr_crc <= 16'd0;
            r_crc     <= crccfv_pkg::CRC_INIT;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_pos     <= '0;
                r_sig_ok  <= 1'b1;
                r_ver_ok  <= 1'b1;
                r_hdr_len <= 16'd0;
                r_hdr_crc <= 16'd0;
                r_crc     <= crccfv_pkg::CRC_INIT;
            end else begin
                r_pos     <= n_pos;
                r_sig_ok  <= n_sig_ok;
                r_ver_ok  <= n_ver_ok;
                r_hdr_len <= n_hdr_len;
                r_hdr_crc <= n_hdr_crc;
                r_crc     <= n_crc;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_status <= n_status;
            if (n_status == crccfv_pkg::STATUS_SHORT) begin
                r_out_len <= 16'd0;
                r_out_crc <= 16'd0;
            end else begin
                r_out_len <= n_hdr_len;
                r_out_crc <= n_crc;
            end
        end
    end

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> r_out_valid)
        else $error("last byte did not produce a result");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_pos == '0 && r_sig_ok && r_ver_ok
                                  && r_crc == crccfv_pkg::CRC_INIT))
        else $error("frame state not cleared after last byte");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_last && r_pos != crccfv_pkg::POS_MAX)
        |=> r_pos == $past(r_pos) + 1'b1)
        else $error("byte position did not advance");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == crccfv_pkg::STATUS_SHORT)
        |-> (r_out_len == 16'd0 && r_out_crc == 16'd0))
        else $error("short frame reports nonzero fields");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(w_adv && r_in_last))
        else $error("pending result overwritten");
`endif

endmodule

/* bench/crc_checked_frame_validator_unit_test.sv */
// Self-checking bench for crc_checked_frame_validator_unit: byte frames in,
// one status per last byte out, predicted in the bench and compared per field.
// Depends on crccfv_pkg and the unit itself.
`timescale 1ns / 100ps

module crc_checked_frame_validator_unit_test;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        crccfv_pkg::t_status status;
        logic [15:0]         length;
        logic [15:0]         crc;
    } t_frame_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [crccfv_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // m_axis_tdata: [2:0] status, [18:3] payload_length, [34:19] crc_value, [39:35] zero

    // bench copy of the registers and the frame state
    logic [31:0]                  want_signature;
    logic [15:0]                  want_version;
    logic [crccfv_pkg::POS_W-1:0] fr_pos;
    logic                         fr_sig_ok;
    logic                         fr_ver_ok;
    logic [15:0]                  fr_len;
    logic [15:0]                  fr_crc_field;
    logic [15:0]                  fr_crc_acc;

    t_frame_verdict pending_verdicts[$];
    logic [7:0]     frame_q[$];

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int bytes_sent;
    int frames_checked;
    int stall_cycles;
    int status_tally[8];

    crc_checked_frame_validator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // crc-16/ccitt-false, one data bit fed into the top per shift
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            if (r[15] ^ b[i]) begin
                r = {r[14:0], 1'b0} ^ crccfv_pkg::CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic void clear_frame_state();
        fr_pos       = '0;
        fr_sig_ok    = 1'b1;
        fr_ver_ok    = 1'b1;
        fr_len       = '0;
        fr_crc_field = '0;
        fr_crc_acc   = crccfv_pkg::CRC_INIT;
    endfunction

    // advance the frame state by one accepted byte, queue a verdict on the last one
    function automatic void predict_byte(input logic [7:0] b, input logic last_flag);
        int unsigned    p;
        int unsigned    count;
        t_frame_verdict v;
        p = 32'(fr_pos);
        if (p < 4) begin
            if (b != want_signature[8*(3-p) +: 8]) fr_sig_ok = 1'b0;
        end else if (p < 6) begin
            if (b != want_version[8*(5-p) +: 8]) fr_ver_ok = 1'b0;
        end else if (p < 8) begin
            fr_len = {fr_len[7:0], b};
        end else if (p < crccfv_pkg::HEADER_BYTES) begin
            fr_crc_field = {fr_crc_field[7:0], b};
        end else if (p - crccfv_pkg::HEADER_BYTES < fr_len) begin
            fr_crc_acc = crc16_step(fr_crc_acc, b);
        end
        if (fr_pos != crccfv_pkg::POS_MAX) fr_pos = fr_pos + 1'b1;
        if (!last_flag) return;

        count    = 32'(fr_pos);
        v.length = fr_len;
        v.crc    = fr_crc_acc;
        if (count < crccfv_pkg::HEADER_BYTES) begin
            v.status = crccfv_pkg::STATUS_SHORT;
            v.length = '0;
            v.crc    = '0;
        end else if (!fr_sig_ok) begin
            v.status = crccfv_pkg::STATUS_BAD_SIG;
        end else if (!fr_ver_ok) begin
            v.status = crccfv_pkg::STATUS_BAD_VER;
        end else if (crccfv_pkg::HEADER_BYTES + fr_len > count) begin
            v.status = crccfv_pkg::STATUS_TRUNCATED;
        end else if (fr_crc_acc != fr_crc_field) begin
            v.status = crccfv_pkg::STATUS_CRC_ERR;
        end else begin
            v.status = crccfv_pkg::STATUS_OK;
        end
        pending_verdicts.push_back(v);
        clear_frame_state();
    endfunction

    // starts at a falling edge or a taken request, returns at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic last_flag);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last_flag;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        predict_byte(b, last_flag);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    task automatic hold_source();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == crccfv_pkg::CFG_SIGNATURE) begin
            want_signature = value;
        end else begin
            want_version = value[15:0];
        end
    endtask

    // registers only change with nothing in flight
    task automatic set_config(input logic [31:0] sig, input logic [15:0] ver);
        hold_source();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_register(crccfv_pkg::CFG_SIGNATURE, sig);
        write_register(crccfv_pkg::CFG_VERSION, {16'h0000, ver});
    endtask

    // header + body; crc covers the first plen body bytes that exist
    task automatic compose_frame(input logic [31:0] sig, input logic [15:0] ver,
                                 input int plen, input int body_len,
                                 input logic [15:0] crc_flip);
        logic [15:0] crc;
        logic [7:0]  b;
        logic [7:0]  body[$];
        crc = crccfv_pkg::CRC_INIT;
        for (int i = 0; i < body_len; i++) begin
            b = 8'($urandom_range(255));
            body.push_back(b);
            if (i < plen) crc = crc16_step(crc, b);
        end
        crc = crc ^ crc_flip;
        frame_q = {sig[31:24], sig[23:16], sig[15:8], sig[7:0], ver[15:8], ver[7:0],
                   8'(plen >> 8), 8'(plen), crc[15:8], crc[7:0]};
        frame_q = {frame_q, body};
    endtask

    task automatic test_directed_frames();
        // single byte buffer
        frame_q = {8'hFF};
        send_frame();
        // empty payload, crc field equals the init value
        compose_frame(want_signature, want_version, 0, 0, 16'h0000);
        send_frame();
        // signature and version both wrong: signature wins
        compose_frame(~want_signature, ~want_version, 0, 0, 16'h0000);
        send_frame();
        // payload cut one byte short
        compose_frame(want_signature, want_version, 2, 1, 16'h0000);
        send_frame();
        // bad crc with a trailing byte past the payload
        compose_frame(want_signature, want_version, 1, 2, 16'h0001);
        send_frame();
    endtask

    task automatic test_random_frames(input int n_bytes, input logic [31:0] sig_cfg,
                                      input logic [15:0] ver_cfg);
        int          start;
        int          pick;
        int          plen;
        int          body_len;
        int          n;
        logic [31:0] sig;
        logic [15:0] ver;
        logic [15:0] flip;
        set_config(sig_cfg, ver_cfg);
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            n    = $urandom_range(99);
            plen = (n < 80) ? $urandom_range(12) : (n < 95) ? $urandom_range(64)
                                                            : $urandom_range(300);
            body_len = plen + (($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0);
            sig  = want_signature;
            ver  = want_version;
            flip = 16'h0000;
            if (pick < 60) begin
                compose_frame(sig, ver, plen, body_len, flip);
            end else if (pick < 68) begin
                flip = 16'($urandom_range(1, 65535));
                compose_frame(sig, ver, plen, body_len, flip);
            end else if (pick < 75) begin
                sig = sig ^ (32'h1 << $urandom_range(31));
                if ($urandom_range(1)) ver = ver ^ 16'($urandom_range(1, 65535));
                compose_frame(sig, ver, plen, body_len, flip);
            end else if (pick < 82) begin
                ver = ver ^ (16'h1 << $urandom_range(15));
                compose_frame(sig, ver, plen, body_len, flip);
            end else if (pick < 88) begin
                // truncated, sometimes with a huge declared length
                if ($urandom_range(1)) plen = $urandom_range(1, 65535);
                else plen = $urandom_range(1, 40);
                compose_frame(sig, ver, plen, $urandom_range(0, plen < 20 ? plen - 1 : 19),
                              flip);
            end else if (pick < 94) begin
                compose_frame(sig, ver, plen, body_len, flip);
                frame_q = frame_q[0:$urandom_range(8)];
            end else begin
                frame_q.delete();
                repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(255)));
            end
            send_frame();
            // now and then let every status come back before going on
            if ($urandom_range(11) == 0) begin
                hold_source();
                wait_drained();
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_frame_verdict      want;
        crccfv_pkg::t_status got_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = crccfv_pkg::t_status'(m_axis_tdata[2:0]);
            status_tally[m_axis_tdata[2:0]]++;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected status request, expected none actual status %0d",
                         $time, m_axis_tdata[2:0]);
            end else begin
                want = pending_verdicts.pop_front();
                frames_checked++;
                if (got_status != want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got_status);
                end
                if (m_axis_tdata[18:3] != want.length) begin
                    mismatches++;
                    $display("%0t: payload_length expected %h actual %h", $time,
                             want.length, m_axis_tdata[18:3]);
                end
                if (m_axis_tdata[34:19] != want.crc) begin
                    mismatches++;
                    $display("%0t: crc_value expected %h actual %h", $time, want.crc,
                             m_axis_tdata[34:19]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request taken for %0d cycles", $time, stall_cycles);
            $display("crc_checked_frame_validator_unit_test NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = crccfv_pkg::CFG_SIGNATURE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_idle_pct  = 15;
        sink_idle_pct = 69;
        bytes_sent    = 0;
        want_signature = '0;
        want_version   = '0;
        clear_frame_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_directed_frames();
        test_random_frames(275, 32'hFFFF_FFFF, 16'hFFFF);
        test_random_frames(275, $urandom, 16'($urandom));

        src_idle_pct  = 69;
        sink_idle_pct = 15;
        test_random_frames(275, 32'h0000_0000, 16'h0000);
        test_random_frames(275, $urandom, 16'($urandom));

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_frames(550, $urandom, 16'($urandom));

        hold_source();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $display("%0t: status requests left expected 0 actual %0d", $time,
                     pending_verdicts.size());
        end
        $display("covered %0d bytes in %0d frames over three idle mixes and five settings",
                 bytes_sent, frames_checked);
        $display("ok %0d short %0d bad sig %0d bad ver %0d truncated %0d crc err %0d",
                 status_tally[crccfv_pkg::STATUS_OK], status_tally[crccfv_pkg::STATUS_SHORT],
                 status_tally[crccfv_pkg::STATUS_BAD_SIG],
                 status_tally[crccfv_pkg::STATUS_BAD_VER],
                 status_tally[crccfv_pkg::STATUS_TRUNCATED],
                 status_tally[crccfv_pkg::STATUS_CRC_ERR]);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("crc_checked_frame_validator_unit_test OK");
        end else begin
            $display("crc_checked_frame_validator_unit_test NOT OK");
        end
        $finish;
    end

endmodule
